// File: rtl/core/qbpu_pkg.sv
// Package for the quadword byte permute unit.
// Holds the operation codes, the byte-vector type and shuffle constants.
// No dependencies.
package qbpu_pkg;

    localparam int unsigned NUM_BYTES = 16;

    // Byte 0 is the most significant byte of the 128-bit quadword.
    typedef logic [0:NUM_BYTES-1][7:0] qw_bytes_t;
    typedef logic [1:0]                op_t;
    typedef logic [3:0]                byte_idx_t;
    typedef logic [4:0]                count_t;

    localparam op_t OP_SHUFFLE = 2'd0;
    localparam op_t OP_SHL     = 2'd1;
    localparam op_t OP_ROL     = 2'd2;
    localparam op_t OP_SHR     = 2'd3;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [7:0] BYTE_SIGN = 8'h80;

endpackage

// File: rtl/core/qbpu_lane.sv
// One byte lane of the permute unit: picks result byte lane_idx for any operation.
// Depends on qbpu_pkg.
module qbpu_lane (
    input  qbpu_pkg::byte_idx_t lane_idx,
    input  qbpu_pkg::op_t       op,
    input  qbpu_pkg::count_t    count,
    input  qbpu_pkg::qw_bytes_t a_bytes,
    input  qbpu_pkg::qw_bytes_t b_bytes,
    input  logic [7:0]          sel_byte,
    output logic [7:0]          lane_byte
);

    logic [5:0]          shl_sum;
    qbpu_pkg::byte_idx_t rol_idx;
    qbpu_pkg::byte_idx_t shr_idx;
    logic [7:0]          shuf_byte;

    assign shl_sum = {2'b00, lane_idx} + {1'b0, count};
    assign rol_idx = lane_idx + count[3:0];
    assign shr_idx = lane_idx - count[3:0];

    always_comb begin
        if (sel_byte[7:6] == 2'b10) begin
            shuf_byte = qbpu_pkg::BYTE_ZERO;
        end else if (sel_byte[7:5] == 3'b110) begin
            shuf_byte = qbpu_pkg::BYTE_ONES;
        end else if (sel_byte[7:5] == 3'b111) begin
            shuf_byte = qbpu_pkg::BYTE_SIGN;
        end else if (sel_byte[4]) begin
            shuf_byte = b_bytes[sel_byte[3:0]];
        end else begin
            shuf_byte = a_bytes[sel_byte[3:0]];
        end
    end

    always_comb begin
        case (op)
            qbpu_pkg::OP_SHUFFLE: begin
                lane_byte = shuf_byte;
            end
            qbpu_pkg::OP_SHL: begin
                // bytes pulled from beyond byte 15 are zero
                lane_byte = (shl_sum[5:4] != 2'b00) ? qbpu_pkg::BYTE_ZERO
                                                    : a_bytes[shl_sum[3:0]];
            end
            qbpu_pkg::OP_ROL: begin
                lane_byte = a_bytes[rol_idx];
            end
            qbpu_pkg::OP_SHR: begin
                lane_byte = ({1'b0, lane_idx} >= count) ? a_bytes[shr_idx]
                                                        : qbpu_pkg::BYTE_ZERO;
            end
            default: begin
                lane_byte = qbpu_pkg::BYTE_ZERO;
            end
        endcase
    end

endmodule

// File: rtl/core/qbpu_merge.sv
// Merge stage: gathers the sixteen lane bytes into the registered result beat.
// Depends on qbpu_pkg.
module qbpu_merge (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  qbpu_pkg::qw_bytes_t lane_bytes,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         result_hi,
    output logic [63:0]         result_lo
);

    logic        valid_reg;
    logic        valid_next;
    logic [127:0] data_reg;
    logic        load;

    // take a new beat whenever the output register is empty or drains this cycle
    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= lane_bytes;
        end
    end

    assign out_valid = valid_reg;
    assign result_hi = data_reg[127:64];
    assign result_lo = data_reg[63:0];

endmodule

// File: rtl/core/quadword_byte_permute_unit.sv
// Quadword byte permute unit: shuffle, byte shift and byte rotate of 128-bit values.
// The result beat is registered and valid in the cycle after the request beat is taken.
// Throughput: one beat per cycle while the result side takes results; sixteen byte lanes work in parallel and feed
// a single output register, which also holds the result and blocks new beats when the result side stalls.
// Reset (aresetn low, synchronous) empties the output register; the result data itself is not reset.
module quadword_byte_permute_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [63:0] s_a_hi,
    input  logic [63:0] s_a_lo,
    input  logic [63:0] s_b_hi,
    input  logic [63:0] s_b_lo,
    input  logic [63:0] s_sel_hi,
    input  logic [63:0] s_sel_lo,
    input  logic [4:0]  s_shift_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_hi,
    output logic [63:0] m_result_lo
);

    qbpu_pkg::qw_bytes_t a_bytes;
    qbpu_pkg::qw_bytes_t b_bytes;
    qbpu_pkg::qw_bytes_t sel_bytes;
    qbpu_pkg::qw_bytes_t lane_bytes;

    assign a_bytes   = {s_a_hi, s_a_lo};
    assign b_bytes   = {s_b_hi, s_b_lo};
    assign sel_bytes = {s_sel_hi, s_sel_lo};

    for (genvar i = 0; i < qbpu_pkg::NUM_BYTES; i++) begin : g_lane
        qbpu_lane u_lane (
            .lane_idx  (4'(i)),
            .op        (s_req_type),
            .count     (s_shift_count),
            .a_bytes   (a_bytes),
            .b_bytes   (b_bytes),
            .sel_byte  (sel_bytes[i]),
            .lane_byte (lane_bytes[i])
        );
    end

    qbpu_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .lane_bytes (lane_bytes),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .result_hi  (m_result_hi),
        .result_lo  (m_result_lo)
    );

endmodule

// File: rtl/core/qbpu_checker.sv
// Port-level checker for the quadword byte permute unit, bound to the top level.
// Depends on qbpu_pkg and quadword_byte_permute_unit.
module qbpu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_req_type,
    input logic [63:0] s_a_hi,
    input logic [63:0] s_a_lo,
    input logic [4:0]  s_shift_count,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_result_hi,
    input logic [63:0] m_result_lo
);

    // an accepted beat shows up on the result side in the next cycle
    a_accept_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted beat did not produce a result beat");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_hi) && $stable(m_result_lo))
        else $error("stalled result beat changed");

    // an empty output register never blocks the request side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request side blocked while result side is empty");

    // a full output register that is not drained blocks new beats
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("request taken over a stalled result");

    // rotate by zero passes a through unchanged
    a_rotate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req_type == qbpu_pkg::OP_ROL && s_shift_count[3:0] == 4'd0
        |=> m_result_hi == $past(s_a_hi) && m_result_lo == $past(s_a_lo))
        else $error("rotate by zero altered the quadword");

endmodule

bind quadword_byte_permute_unit qbpu_checker u_qbpu_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_req_type    (s_req_type),
    .s_a_hi        (s_a_hi),
    .s_a_lo        (s_a_lo),
    .s_shift_count (s_shift_count),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_hi   (m_result_hi),
    .m_result_lo   (m_result_lo)
);

// File: tb/sv/qbpu_result_checker.sv
// Result checker for the quadword byte permute unit.
// Watches both channels, predicts each result quadword and compares it.
// Depends on qbpu_pkg for the operation codes and the byte-vector type.
`timescale 1ns / 1ps

module qbpu_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [63:0] s_a_hi,
    input  logic [63:0] s_a_lo,
    input  logic [63:0] s_b_hi,
    input  logic [63:0] s_b_lo,
    input  logic [63:0] s_sel_hi,
    input  logic [63:0] s_sel_lo,
    input  logic [4:0]  s_shift_count,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_result_hi,
    input  logic [63:0] m_result_lo,
    output int unsigned mismatch_count,
    output int unsigned outstanding
);

    logic [127:0] expected_quadwords[$];
    int unsigned  beats_checked;

    function automatic qbpu_pkg::qw_bytes_t permute_quadword(
        input qbpu_pkg::op_t op, input qbpu_pkg::qw_bytes_t a,
        input qbpu_pkg::qw_bytes_t b, input qbpu_pkg::qw_bytes_t sel,
        input qbpu_pkg::count_t cnt);
        qbpu_pkg::qw_bytes_t r;
        logic [7:0]          s;
        int                  src;
        for (int i = 0; i < qbpu_pkg::NUM_BYTES; i++) begin
            case (op)
                qbpu_pkg::OP_SHUFFLE: begin
                    s = sel[i];
                    if (s[7:6] == 2'b10)
                        r[i] = qbpu_pkg::BYTE_ZERO;
                    else if (s[7:5] == 3'b110)
                        r[i] = qbpu_pkg::BYTE_ONES;
                    else if (s[7:5] == 3'b111)
                        r[i] = qbpu_pkg::BYTE_SIGN;
                    else if (s[4])
                        r[i] = b[s[3:0]];
                    else
                        r[i] = a[s[3:0]];
                end
                qbpu_pkg::OP_SHL: begin
                    src  = i + int'(cnt);
                    r[i] = (src < 16) ? a[src] : qbpu_pkg::BYTE_ZERO;
                end
                qbpu_pkg::OP_ROL: begin
                    src  = (i + int'(cnt[3:0])) % 16;
                    r[i] = a[src];
                end
                default: begin
                    src  = i - int'(cnt);
                    r[i] = (src >= 0) ? a[src] : qbpu_pkg::BYTE_ZERO;
                end
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: beat %0d %s", $realtime, beats_checked, msg);
        mismatch_count++;
    endtask

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
        beats_checked  = 0;
    end

    always @(posedge aclk) begin
        logic [127:0] want;
        if (!aresetn) begin
            expected_quadwords.delete();
        end else begin
            if (s_valid && s_ready)
                expected_quadwords.push_back(permute_quadword(s_req_type, {s_a_hi, s_a_lo},
                    {s_b_hi, s_b_lo}, {s_sel_hi, s_sel_lo}, s_shift_count));
            if (m_valid && m_ready) begin
                if (expected_quadwords.size() == 0) begin
                    report_mismatch($sformatf("result %h_%h with nothing expected",
                                              m_result_hi, m_result_lo));
                end else begin
                    want = expected_quadwords.pop_front();
                    if (m_result_hi !== want[127:64])
                        report_mismatch($sformatf("result_hi mismatch: expected %h, got %h",
                                                  want[127:64], m_result_hi));
                    if (m_result_lo !== want[63:0])
                        report_mismatch($sformatf("result_lo mismatch: expected %h, got %h",
                                                  want[63:0], m_result_lo));
                end
                beats_checked++;
            end
        end
        // publish after the edge so readers at the next edge see this edge's state
        outstanding <= expected_quadwords.size();
    end

endmodule

// File: tb/sv/testbench.sv
// Top of the quadword byte permute unit testbench: clock, reset, stimulus, verdict.
// Drives directed then random requests, with random idling on both channels outside the back-to-back phases.
// Depends on qbpu_pkg, quadword_byte_permute_unit and qbpu_result_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned RANDOM_REQUESTS = 2000;
    localparam int unsigned PHASE_LENGTH    = 250;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned HOLD_AT_RESULT  = 400;
    localparam int unsigned HOLD_CYCLES     = 300;

    typedef struct {
        qbpu_pkg::op_t    op;
        logic [63:0]      a_hi, a_lo, b_hi, b_lo, sel_hi, sel_lo;
        qbpu_pkg::count_t count;
    } permute_req_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [63:0] s_a_hi, s_a_lo, s_b_hi, s_b_lo, s_sel_hi, s_sel_lo;
    logic [4:0]  s_shift_count;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_result_hi, m_result_lo;
    int unsigned mismatch_count;
    int unsigned outstanding;
    int unsigned cycle_count = 0;
    bit          no_idle = 1'b0;

    quadword_byte_permute_unit dut (.*);

    qbpu_result_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic permute_req_t random_request();
        permute_req_t req;
        req.op     = qbpu_pkg::op_t'($urandom_range(0, 3));
        req.a_hi   = rand64();
        req.a_lo   = rand64();
        req.b_hi   = rand64();
        req.b_lo   = rand64();
        req.sel_hi = rand64();
        req.sel_lo = rand64();
        req.count  = qbpu_pkg::count_t'($urandom_range(0, 31));
        return req;
    endfunction

    // Offer one beat after a random gap and hold it until accepted.
    task automatic send_beat(input permute_req_t req);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req.op;
        s_a_hi        <= req.a_hi;
        s_a_lo        <= req.a_lo;
        s_b_hi        <= req.b_hi;
        s_b_lo        <= req.b_lo;
        s_sel_hi      <= req.sel_hi;
        s_sel_lo      <= req.sel_lo;
        s_shift_count <= req.count;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_shift(input qbpu_pkg::op_t op, input qbpu_pkg::count_t count);
        permute_req_t req;
        req       = random_request();
        req.op    = op;
        req.a_hi  = 64'h0011223344556677;
        req.a_lo  = 64'h8899AABBCCDDEEFF;
        req.count = count;
        send_beat(req);
    endtask

    task automatic send_shuffle(input logic [63:0] a_hi, a_lo, b_hi, b_lo, sel_hi, sel_lo);
        permute_req_t req;
        req        = random_request();
        req.op     = qbpu_pkg::OP_SHUFFLE;
        req.a_hi   = a_hi;
        req.a_lo   = a_lo;
        req.b_hi   = b_hi;
        req.b_lo   = b_lo;
        req.sel_hi = sel_hi;
        req.sel_lo = sel_lo;
        send_beat(req);
    endtask

    // Drop valid and wait until the checker has nothing left to see.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Result side: random stall per beat, plus one long hold-off to back up the unit.
    initial begin
        int unsigned stall;
        int unsigned results_taken;
        results_taken = 0;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 16);
            if (results_taken == HOLD_AT_RESULT)
                stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_req_type    = qbpu_pkg::OP_SHUFFLE;
        s_a_hi        = '0;
        s_a_lo        = '0;
        s_b_hi        = '0;
        s_b_lo        = '0;
        s_sel_hi      = '0;
        s_sel_lo      = '0;
        s_shift_count = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity picks from a, then from b
        send_shuffle(64'h0011223344556677, 64'h8899AABBCCDDEEFF, rand64(), rand64(),
                     64'h0001020304050607, 64'h08090A0B0C0D0E0F);
        send_shuffle(rand64(), rand64(), 64'h0123456789ABCDEF, 64'hFEDCBA9876543210,
                     64'h1011121314151617, 64'h18191A1B1C1D1E1F);
        // constant patterns at their edges, and high selector bits that must be ignored
        send_shuffle(64'h0011223344556677, 64'h8899AABBCCDDEEFF, 64'h0123456789ABCDEF,
                     64'hFEDCBA9876543210, 64'h80BFC0DFE0FF0F1F, 64'h7F6F604F502F3A25);
        send_shuffle('1, '1, '1, '1, '1, '1);
        send_shuffle('1, '1, '0, '0, 64'h00100F1F70607F6F, 64'h8090A0B0C8D0E8F8);
        send_shuffle('0, '0, '1, '1, 64'h00100F1F70607F6F, 64'h0000000000000000);
        send_shift(qbpu_pkg::OP_SHL, 5'd0);
        send_shift(qbpu_pkg::OP_SHL, 5'd1);
        send_shift(qbpu_pkg::OP_SHL, 5'd15);
        send_shift(qbpu_pkg::OP_SHL, 5'd16);
        send_shift(qbpu_pkg::OP_SHL, 5'd31);
        send_shift(qbpu_pkg::OP_ROL, 5'd0);
        send_shift(qbpu_pkg::OP_ROL, 5'd1);
        send_shift(qbpu_pkg::OP_ROL, 5'd15);
        send_shift(qbpu_pkg::OP_ROL, 5'd16);
        send_shift(qbpu_pkg::OP_ROL, 5'd31);
        send_shift(qbpu_pkg::OP_SHR, 5'd0);
        send_shift(qbpu_pkg::OP_SHR, 5'd1);
        send_shift(qbpu_pkg::OP_SHR, 5'd15);
        send_shift(qbpu_pkg::OP_SHR, 5'd16);
        send_shift(qbpu_pkg::OP_SHR, 5'd31);
        wait_drained();

        // alternate idling phases with back-to-back phases
        for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
            no_idle = ((n / PHASE_LENGTH) % 2) == 1;
            if (n == 3 * PHASE_LENGTH)
                wait_drained();
            send_beat(random_request());
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
rtl/core/qbpu_pkg.sv
rtl/core/qbpu_lane.sv
rtl/core/qbpu_merge.sv
rtl/core/quadword_byte_permute_unit.sv
rtl/core/qbpu_checker.sv
tb/sv/qbpu_result_checker.sv
tb/sv/testbench.sv
